// ===== rtl/kdbst_pkg.sv =====
package kdbst_pkg;

	localparam int unsigned ByteW    = 8;
	localparam int unsigned Depth    = 256;
	localparam int unsigned KeyW     = 64;
	localparam int unsigned CfgIdxW  = 2;

	localparam logic [CfgIdxW-1:0] CFG_KEY  = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_KIND = 2'd1;

	localparam logic [ByteW-1:0] FIX_MUL = 8'd13;
	localparam logic [ByteW-1:0] FIX_ADD = 8'd11;
	localparam logic [ByteW-1:0] BYTE_LO = 8'h00;
	localparam logic [ByteW-1:0] BYTE_HI = 8'hff;

	typedef struct packed {
		logic             en;
		logic [ByteW-1:0] addr;
		logic [ByteW-1:0] data;
	} wr_t;

	// a^n mod 16 for a of 5 or 13
	function automatic logic [3:0] lcg_pow(input logic a13, input logic [3:0] n);
		logic [3:0] p;
		begin
			unique case (n[1:0])
				2'd0: p = 4'd1;
				2'd1: p = a13 ? 4'd13 : 4'd5;
				2'd2: p = 4'd9;
				2'd3: p = a13 ? 4'd5 : 4'd13;
				default: p = 4'd1;
			endcase
			return p;
		end
	endfunction

	// sum of a^j for j below n, mod 16
	function automatic logic [3:0] lcg_geo(input logic a13, input logic [3:0] n);
		logic [3:0] g;
		begin
			unique case (n)
				4'd0:  g = 4'd0;
				4'd1:  g = 4'd1;
				4'd2:  g = a13 ? 4'd14 : 4'd6;
				4'd3:  g = a13 ? 4'd7  : 4'd15;
				4'd4:  g = 4'd12;
				4'd5:  g = 4'd13;
				4'd6:  g = a13 ? 4'd10 : 4'd2;
				4'd7:  g = a13 ? 4'd3  : 4'd11;
				4'd8:  g = 4'd8;
				4'd9:  g = 4'd9;
				4'd10: g = a13 ? 4'd6  : 4'd14;
				4'd11: g = a13 ? 4'd15 : 4'd7;
				4'd12: g = 4'd4;
				4'd13: g = 4'd5;
				4'd14: g = a13 ? 4'd2  : 4'd10;
				4'd15: g = a13 ? 4'd11 : 4'd3;
				default: g = 4'd0;
			endcase
			return g;
		end
	endfunction

	// value of the nibble generator after idx+1 steps
	function automatic logic [3:0] lcg_term(input logic [ByteW-1:0] seed,
			input logic [3:0] idx);
		logic [3:0] n;
		logic [3:0] ad;
		logic [3:0] res;
		begin
			n   = idx + 4'd1;
			ad  = {seed[3:1], 1'b1};
			res = lcg_pow(seed[0], n) * seed[7:4] + ad * lcg_geo(seed[0], n);
			return res;
		end
	endfunction

	function automatic logic [ByteW-1:0] kbyte(input logic [KeyW-1:0] c,
			input int unsigned i);
		return c[8*i +: 8];
	endfunction

	function automatic logic [ByteW-1:0] col_seed(input logic [KeyW-1:0] c,
			input logic [3:0] r);
		logic [ByteW-1:0] s;
		begin
			unique case (r)
				4'd0:  s = kbyte(c, 1);
				4'd1:  s = kbyte(c, 6) ^ kbyte(c, 1);
				4'd2:  s = kbyte(c, 2) ^ kbyte(c, 3);
				4'd3:  s = kbyte(c, 2);
				4'd4:  s = kbyte(c, 1) ^ kbyte(c, 2);
				4'd5:  s = kbyte(c, 3) ^ kbyte(c, 4);
				4'd6:  s = kbyte(c, 3);
				4'd7:  s = kbyte(c, 2) ^ kbyte(c, 3);
				4'd8:  s = kbyte(c, 4) ^ kbyte(c, 5);
				4'd9:  s = kbyte(c, 4);
				4'd10: s = kbyte(c, 3) ^ kbyte(c, 4);
				4'd11: s = kbyte(c, 5) ^ kbyte(c, 6);
				4'd12: s = kbyte(c, 5);
				4'd13: s = kbyte(c, 4) ^ kbyte(c, 5);
				4'd14: s = kbyte(c, 6) ^ kbyte(c, 1);
				4'd15: s = kbyte(c, 6);
				default: s = kbyte(c, 1);
			endcase
			return s;
		end
	endfunction

endpackage

// ===== rtl/kdbst_ram.sv =====
module kdbst_ram
	import kdbst_pkg::*;
(
	input  logic             clk,
	input  wr_t              wr,
	input  logic             re,
	input  logic [ByteW-1:0] raddr,
	output logic [ByteW-1:0] rdata
);

	logic [ByteW-1:0] mem_q [Depth];
	logic [ByteW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/kdbst_builder.sv =====
module kdbst_builder
	import kdbst_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [KeyW-1:0]    cfg_wdata,
	output logic               busy,
	output wr_t                dec_wr,
	output wr_t                enc_wr
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} bstate_t;

	bstate_t          state_q;
	logic [KeyW-1:0]  ckey_q;
	logic             key_zero_q;
	logic             kind_q;
	logic [ByteW-1:0] cnt_q;
	logic [ByteW-1:0] pos_q;
	logic [ByteW-1:0] x_q;

	logic             start;
	logic             run;
	logic             last;
	logic [ByteW-1:0] fix_next;
	logic [ByteW-1:0] m;
	logic [3:0]       r;
	logic [3:0]       k;
	logic [ByteW-1:0] keyed_val;
	logic [ByteW-1:0] v;
	logic             edge_val;

	assign start = cfg_we && (cfg_index == CFG_KEY || cfg_index == CFG_KIND);
	assign run   = (state_q == ST_RUN);
	assign last  = (cnt_q == BYTE_HI);

	// stride 17 walk: low nibble is the step count, high nibble adds its carry
	assign m         = cnt_q + 8'd1;
	assign k         = m[3:0];
	assign r         = m[3:0] + m[7:4];
	assign keyed_val = {lcg_term(ckey_q[7:0], r), lcg_term(col_seed(ckey_q, r), k)};
	assign fix_next  = x_q * FIX_MUL + FIX_ADD;

	always_comb begin
		priority if (kind_q) begin
			v = fix_next;
		end else if (key_zero_q) begin
			v = cnt_q;
		end else begin
			v = keyed_val;
		end
	end

	assign edge_val = (v == BYTE_LO) || (v == BYTE_HI);

	always_comb begin
		dec_wr.en   = run;
		enc_wr.en   = run;
		enc_wr.addr = v;
		if (edge_val) begin
			dec_wr.addr = v;
			dec_wr.data = v;
			enc_wr.data = v;
		end else begin
			dec_wr.addr = pos_q;
			dec_wr.data = v;
			enc_wr.data = pos_q;
		end
	end

	assign busy = run;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ckey_q     <= '1;
			key_zero_q <= 1'b1;
			kind_q     <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_KEY: begin
					ckey_q     <= cfg_wdata - 64'd1;
					key_zero_q <= (cfg_wdata == '0);
				end
				CFG_KIND: begin
					kind_q <= cfg_wdata[0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
			cnt_q   <= '0;
			pos_q   <= 8'd1;
			x_q     <= '0;
		end else if (start) begin
			state_q <= ST_RUN;
			cnt_q   <= '0;
			pos_q   <= 8'd1;
			x_q     <= '0;
		end else if (run) begin
			cnt_q <= cnt_q + 8'd1;
			x_q   <= fix_next;
			if (!edge_val) begin
				pos_q <= pos_q + 8'd1;
			end
			if (last) begin
				state_q <= ST_IDLE;
			end
		end
	end

`ifndef SYNTH
	a_sweep_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(run && last && !start) |=> (state_q == ST_IDLE))
		else $error("table sweep did not end after the last entry");

	a_pos_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(run && !edge_val) |-> (pos_q != BYTE_LO))
		else $error("fill position wrapped");

	a_start_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> (run && cnt_q == BYTE_LO && pos_q == 8'd1))
		else $error("register write did not restart the sweep");
`endif

endmodule

// ===== rtl/kdbst_lookup.sv =====
module kdbst_lookup
	import kdbst_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 hold,
	input  wr_t                  dec_wr,
	input  wr_t                  enc_wr,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [ByteW-1:0]     s_tdata,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [2*ByteW-1:0]   m_tdata
);

	logic             valid_s1;
	logic             valid_s2;
	logic [ByteW-1:0] dec_s2;
	logic [ByteW-1:0] enc_s2;
	logic [ByteW-1:0] dec_rd;
	logic [ByteW-1:0] enc_rd;
	logic             out_free;
	logic             s_acc;

	assign out_free = !valid_s2 || m_tready;
	assign s_tready = !hold && (!valid_s1 || out_free);
	assign s_acc    = s_tvalid && s_tready;

	kdbst_ram u_dec_ram (
		.clk   (clk),
		.wr    (dec_wr),
		.re    (s_acc),
		.raddr (s_tdata),
		.rdata (dec_rd)
	);

	kdbst_ram u_enc_ram (
		.clk   (clk),
		.wr    (enc_wr),
		.re    (s_acc),
		.raddr (s_tdata),
		.rdata (enc_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_acc) begin
				valid_s1 <= 1'b1;
			end else if (out_free) begin
				valid_s1 <= 1'b0;
			end
			if (out_free) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s1) begin
			dec_s2 <= dec_rd;
			enc_s2 <= enc_rd;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {enc_s2, dec_s2};

`ifndef SYNTH
	a_no_accept_in_build: assert property (@(posedge clk) disable iff (!arst_n)
		hold |-> !s_tready)
		else $error("byte accepted while tables are rebuilt");

	a_read_lands: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc |=> valid_s1)
		else $error("accepted byte lost before the output stage");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && !m_tready) |=> (valid_s1 && valid_s2))
		else $error("pipeline dropped a byte while stalled");
`endif

endmodule

// ===== rtl/key_derived_byte_substitution_tables_unit.sv =====
// Byte substitution through a stored table and its inverse. Each byte taken on the slave side
// is looked up in both tables and one transaction leaves on the master side, decrypted byte in
// the low half and encrypted byte in the high half. One byte is taken per cycle unless a
// rebuild or m_tready stalls the flow; each result passes through the synchronous table read,
// then the output register. After reset and after every write to key_code or table_kind both
// tables are rebuilt in one sweep, one table entry a cycle through the write port of each
// memory; s_tready stays low during the sweep. table_kind selects the fixed sequence table,
// otherwise a zero key gives the identity table and any other key the keyed table.
module key_derived_byte_substitution_tables_unit
	import kdbst_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [KeyW-1:0]    cfg_wdata,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [7:0]         s_tdata,   // byte_in
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [15:0]        m_tdata    // decrypted_byte, encrypted_byte
);

	logic busy;
	wr_t  dec_wr;
	wr_t  enc_wr;

	kdbst_builder u_builder (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.busy      (busy),
		.dec_wr    (dec_wr),
		.enc_wr    (enc_wr)
	);

	kdbst_lookup u_lookup (
		.clk      (clk),
		.arst_n   (arst_n),
		.hold     (busy || cfg_we),
		.dec_wr   (dec_wr),
		.enc_wr   (enc_wr),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

// ===== sim/key_derived_byte_substitution_tables_unit_test.sv =====
`timescale 1ns / 1ps

module key_derived_byte_substitution_tables_unit_test;
	import kdbst_pkg::*;

	localparam logic [CfgIdxW-1:0] CFG_SPARE_A = 2'd2;
	localparam logic [CfgIdxW-1:0] CFG_SPARE_B = 2'd3;
	localparam int unsigned        STALL_LIMIT = 4000;

	typedef struct packed {
		logic [ByteW-1:0] enc;
		logic [ByteW-1:0] dec;
	} lookup_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [CfgIdxW-1:0] cfg_index = '0;
	logic [KeyW-1:0]    cfg_wdata = '0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [7:0]         s_tdata = '0;   // byte_in
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [15:0]        m_tdata;        // decrypted_byte, encrypted_byte

	logic [KeyW-1:0]    key_reg = '0;
	logic               kind_reg = 1'b0;
	logic [ByteW-1:0]   dec_tab [Depth];
	logic [ByteW-1:0]   enc_tab [Depth];
	lookup_t            lookup_q [$];
	int unsigned        err_count = 0;
	int unsigned        quiet_cycles = 0;
	bit                 no_idle = 1'b0;

	key_derived_byte_substitution_tables_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// sixteen steps of the mod-16 generator, step i in nibble i
	function automatic logic [63:0] nibble_walk(input logic [7:0] seed);
		logic [3:0]  x;
		logic [3:0]  mul;
		logic [3:0]  add;
		logic [63:0] w;
		x   = seed[7:4];
		mul = {seed[0], 3'b101};
		add = {seed[3:1], 1'b1};
		w   = '0;
		for (int i = 0; i < 16; i++) begin
			x = x * mul + add;
			w[4*i +: 4] = x;
		end
		return w;
	endfunction

	function automatic void rebuild_tables();
		logic [63:0] c;
		logic [7:0]  kb [8];
		logic [7:0]  seeds [16];
		logic [63:0] rows;
		logic [63:0] cols;
		logic [7:0]  raw [256];
		logic [7:0]  x;
		int          pos;
		for (int i = 0; i < 256; i++)
			dec_tab[i] = '0;
		x   = '0;
		pos = 1;
		if (kind_reg) begin
			for (int i = 0; i < 256; i++) begin
				x = x * 8'd13 + 8'd11;
				if (x != BYTE_LO && x != BYTE_HI && pos < 256) begin
					dec_tab[pos] = x;
					pos++;
				end
			end
			dec_tab[0]   = BYTE_LO;
			dec_tab[255] = BYTE_HI;
		end else if (key_reg == '0) begin
			for (int i = 0; i < 256; i++)
				dec_tab[i] = 8'(i);
		end else begin
			c = key_reg - 64'd1;
			for (int i = 0; i < 8; i++)
				kb[i] = c[8*i +: 8];
			seeds[0]  = kb[1];
			seeds[1]  = kb[6] ^ kb[1];
			seeds[2]  = kb[2] ^ kb[3];
			seeds[3]  = kb[2];
			seeds[4]  = kb[1] ^ kb[2];
			seeds[5]  = kb[3] ^ kb[4];
			seeds[6]  = kb[3];
			seeds[7]  = kb[2] ^ kb[3];
			seeds[8]  = kb[4] ^ kb[5];
			seeds[9]  = kb[4];
			seeds[10] = kb[3] ^ kb[4];
			seeds[11] = kb[5] ^ kb[6];
			seeds[12] = kb[5];
			seeds[13] = kb[4] ^ kb[5];
			seeds[14] = kb[6] ^ kb[1];
			seeds[15] = kb[6];
			rows = nibble_walk(kb[0]);
			for (int r = 0; r < 16; r++) begin
				cols = nibble_walk(seeds[r]);
				for (int k = 0; k < 16; k++)
					raw[r*16 + k] = {rows[4*r +: 4], cols[4*k +: 4]};
			end
			for (int i = 0; i < 256; i++) begin
				x = x + 8'd17;
				if (raw[x] != BYTE_LO && raw[x] != BYTE_HI && pos < 256) begin
					dec_tab[pos] = raw[x];
					pos++;
				end
			end
			dec_tab[0]   = BYTE_LO;
			dec_tab[255] = BYTE_HI;
		end
		for (int i = 0; i < 256; i++)
			enc_tab[i] = '0;
		for (int i = 0; i < 256; i++)
			enc_tab[dec_tab[i]] = 8'(i);
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		err_count++;
	endtask

	// expected lookups are queued as each byte transaction is taken
	always @(posedge clk) begin
		if (s_tvalid && s_tready)
			lookup_q.push_back(lookup_t'{enc: enc_tab[s_tdata], dec: dec_tab[s_tdata]});
	end

	always @(posedge clk) begin
		lookup_t got;
		lookup_t want;
		if (m_tvalid && m_tready) begin
			got = lookup_t'(m_tdata);
			if (lookup_q.size() == 0) begin
				report_mismatch($sformatf("unexpected result %h", m_tdata));
			end else begin
				want = lookup_q.pop_front();
				if (got.dec !== want.dec)
					report_mismatch($sformatf("decrypted_byte %h, want %h", got.dec, want.dec));
				if (got.enc !== want.enc)
					report_mismatch($sformatf("encrypted_byte %h, want %h", got.enc, want.enc));
			end
		end
	end

	always @(posedge clk) begin
		m_tready <= no_idle || ($urandom_range(0, 99) >= 15);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	task automatic send_byte(input logic [7:0] b);
		if (!no_idle && $urandom_range(0, 99) < 15) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (lookup_q.size() != 0) @(posedge clk);
	endtask

	// rebuild sweep follows a write, so one probe byte goes through before anything else
	task automatic write_register(input logic [CfgIdxW-1:0] idx, input logic [KeyW-1:0] val);
		drain_results();
		repeat (4) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_KEY: begin
				key_reg = val;
				rebuild_tables();
			end
			CFG_KIND: begin
				kind_reg = val[0];
				rebuild_tables();
			end
			default: ;
		endcase
		send_byte(8'($urandom_range(0, 255)));
	endtask

	task automatic test_reset_identity();
		send_byte(8'h00);
		send_byte(8'hff);
		send_byte(8'h5a);
	endtask

	task automatic test_fixed_table();
		write_register(CFG_KIND, 64'hdead_beef_0000_0003);
		send_byte(8'h01);
		send_byte(8'hfe);
		send_byte(8'h80);
	endtask

	task automatic test_mode_priority();
		write_register(CFG_KEY, 64'h0123_4567_89ab_cdef);
		send_byte(8'h7f);
	endtask

	task automatic test_keyed_extremes();
		write_register(CFG_KIND, 64'hffff_ffff_ffff_fffe);
		send_byte(8'h00);
		write_register(CFG_KEY, 64'd1);
		send_byte(8'hff);
		write_register(CFG_KEY, 64'hffff_ffff_ffff_ffff);
		send_byte(8'h33);
		write_register(CFG_KEY, 64'd0);
		send_byte(8'hcc);
	endtask

	task automatic test_spare_index();
		write_register(CFG_KEY, 64'h0030_8801_bfe2_a35c);
		write_register(CFG_SPARE_A, {$urandom(), $urandom()});
		write_register(CFG_SPARE_B, 64'hffff_ffff_ffff_ffff);
		send_byte(8'h96);
	endtask

	task automatic test_random_traffic();
		logic [KeyW-1:0] key;
		int unsigned     pick;
		for (int ph = 0; ph < 14; ph++) begin
			pick = $urandom_range(0, 9);
			case (pick)
				0:       key = '0;
				1:       key = 64'd1;
				2:       key = '1;
				default: key = {$urandom(), $urandom()};
			endcase
			write_register(CFG_KEY, key);
			write_register(CFG_KIND, {$urandom(), 16'($urandom_range(0, 65535)), 15'd0,
				$urandom_range(0, 3) == 0});
			if ($urandom_range(0, 5) == 0)
				write_register($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B,
					{$urandom(), $urandom()});
			no_idle = (ph == 6);
			for (int n = 0; n < 95; n++) begin
				if (ph == 3 && n == 40)
					drain_results();
				send_byte(8'($urandom_range(0, 255)));
			end
			no_idle = 1'b0;
		end
	endtask

	initial begin
		rebuild_tables();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_identity();
		test_fixed_table();
		test_mode_priority();
		test_keyed_extremes();
		test_spare_index();
		test_random_traffic();
		drain_results();
		repeat (10) @(posedge clk);
		if (err_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/kdbst_pkg.sv
rtl/kdbst_ram.sv
rtl/kdbst_builder.sv
rtl/kdbst_lookup.sv
rtl/key_derived_byte_substitution_tables_unit.sv
sim/key_derived_byte_substitution_tables_unit_test.sv
